// ----- sv/fdec7_pkg.sv -----
// Shared constants and types for the 7-tap decimate-by-two line filter.
// No dependencies.
package fdec7_pkg;

  localparam int MAX_LINE_PIXELS = 4096;
  localparam int POS_W = ($clog2(MAX_LINE_PIXELS + 1) < 2) ? 2 : $clog2(MAX_LINE_PIXELS + 1);

  localparam int PIX_W  = 15;
  localparam int TAP_W  = 16;
  localparam int PROD_W = 31;
  localparam int SUM_W  = 32;
  localparam int NTAPS  = 7;
  localparam int FRAC_BITS = 15;

  localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(16384);

  localparam logic signed [TAP_W-1:0] TAPS [NTAPS] = '{
    -16'sd3026, 16'sd64, 16'sd10758, 16'sd17176, 16'sd10758, 16'sd64, -16'sd3026
  };

  // control of one window cell
  typedef struct packed {
    logic shift;
    logic fill;
    logic prod_en;
  } cell_ctl_t;

  // tag that travels with a pending result
  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

endpackage

// ----- sv/fdec7_cell.sv -----
// One tap cell: holds a window sample, passes it to its neighbor, registers sample*tap.
// Depends on fdec7_pkg.
module fdec7_cell
  import fdec7_pkg::*;
(
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic [PIX_W-1:0]         fill_pix,
  input  logic [PIX_W-1:0]         sin,
  input  logic signed [TAP_W-1:0]  tap,
  output logic [PIX_W-1:0]         sample,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [2*TAP_W-1:0] prod_full;

  assign prod_full = $signed({1'b0, sample}) * tap;

  always_ff @(posedge clk) begin
    if (ctl.fill) begin
      sample <= fill_pix;
    end else if (ctl.shift) begin
      sample <= sin;
    end
    if (ctl.prod_en) begin
      prod <= prod_full[PROD_W-1:0];
    end
  end

endmodule

// ----- sv/fdec7_round.sv -----
// Sums the seven tap products, rounds, saturates and holds the output register.
// Depends on fdec7_pkg.
module fdec7_round
  import fdec7_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [PROD_W-1:0] prod [NTAPS],
  input  tag_t                     tag,
  output logic                     take,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [PIX_W-1:0]         pixel_out,
  output logic                     last_out
);

  logic signed [SUM_W-1:0] acc;
  logic [PIX_W-1:0]        sat;

  always_comb begin
    acc = ROUND_BIAS;
    for (int i = 0; i < NTAPS; i++) begin
      acc = acc + SUM_W'(prod[i]);
    end
  end

  // negative clamps to 0, anything at or above 2^30 clamps to full scale
  always_comb begin
    if (acc[SUM_W-1]) begin
      sat = '0;
    end else if (acc[SUM_W-2]) begin
      sat = '1;
    end else begin
      sat = acc[FRAC_BITS+PIX_W-1:FRAC_BITS];
    end
  end

  assign take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= tag.valid;
    end
    if (take && tag.valid) begin
      pixel_out <= sat;
      last_out  <= tag.last;
    end
  end

endmodule

// ----- sv/fir7_line_decimator_by_two_unit.sv -----
// Top level of the 7-tap horizontal decimate-by-two line filter.
// Depends on fdec7_pkg, fdec7_cell, fdec7_round.
//
// Input channel (in_valid/in_stall, pixel_in, line_end) takes one source
// pixel per request; line_end marks the last pixel of a line. A line
// longer than MAX_LINE_PIXELS is cut there and the next pixel opens a new line.
// Output channel (out_valid/out_stall, pixel_out, last_out) gives one
// filtered pixel per even source position; last_out marks the line's last.
// A row of seven cells holds the window; edges are replicated by filling the
// row with the first pixel and shifting the last pixel in again at line end.
// Throughput: one pixel per clock inside a line while in_stall stays low. At
// line end the cell row shifts two or three more times, with in_stall high.
// An output is registered through the window, product and sum stages after
// the request of the pixel three positions past its center.
// While the receiver stalls, the stages in front keep moving until the first
// pending result meets a full stage; then in_stall rises.
// Reset (synchronous, rst) empties the pipeline and starts a new line.
module fir7_line_decimator_by_two_unit
  import fdec7_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [PIX_W-1:0] pixel_in,
  input  logic             line_end,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] pixel_out,
  output logic             last_out
);

  logic [POS_W-1:0] pos;
  logic             flushing;
  logic [1:0]       fstep;
  logic [PIX_W-1:0] fpix;
  logic             fodd;
  logic             fge2;

  tag_t tag1;
  tag_t tag2;

  logic take;
  logic en1;
  logic en2;
  logic in_acc;
  logic acc_end;
  logic flush_step;
  logic emit_next;
  logic last_next;

  cell_ctl_t               cctl;
  logic [PIX_W-1:0]        shift_pix;
  logic [PIX_W-1:0]        win [NTAPS];
  logic signed [PROD_W-1:0] prod [NTAPS];

  assign en2 = !tag2.valid || take;
  assign en1 = !tag1.valid || en2;

  assign in_stall   = flushing || !en1;
  assign in_acc     = in_valid && !in_stall;
  assign acc_end    = line_end || (pos == POS_W'(MAX_LINE_PIXELS - 1));
  assign flush_step = flushing && en1;

  assign shift_pix    = flushing ? fpix : pixel_in;
  assign cctl.fill    = in_acc && (pos == '0);
  assign cctl.shift   = (in_acc && (pos != '0)) || flush_step;
  assign cctl.prod_en = en2 && tag1.valid;

  always_comb begin
    emit_next = 1'b0;
    last_next = 1'b0;
    if (flush_step) begin
      if (fodd) begin
        emit_next = (fstep == 2'd2);
        last_next = (fstep == 2'd2);
      end else begin
        emit_next = (fstep == 2'd3) || ((fstep == 2'd1) && fge2);
        last_next = (fstep == 2'd3);
      end
    end else if (in_acc) begin
      emit_next = (pos >= POS_W'(3)) && pos[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      flushing   <= 1'b0;
      fstep      <= 2'd1;
      tag1.valid <= 1'b0;
      tag1.last  <= 1'b0;
      tag2.valid <= 1'b0;
      tag2.last  <= 1'b0;
    end else begin
      if (in_acc) begin
        if (acc_end) begin
          pos      <= '0;
          flushing <= 1'b1;
          fstep    <= 2'd1;
        end else begin
          pos <= pos + POS_W'(1);
        end
      end else if (flush_step) begin
        fstep <= fstep + 2'd1;
        if (last_next) begin
          flushing <= 1'b0;
        end
      end
      if (en1) begin
        tag1.valid <= emit_next;
        tag1.last  <= last_next;
      end
      if (en2) begin
        tag2 <= tag1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && acc_end) begin
      fpix <= pixel_in;
      fodd <= pos[0];
      fge2 <= (pos >= POS_W'(2));
    end
  end

  for (genvar i = 0; i < NTAPS; i++) begin : g_cell
    if (i == NTAPS - 1) begin : g_head
      fdec7_cell u_cell (
        .clk      (clk),
        .ctl      (cctl),
        .fill_pix (pixel_in),
        .sin      (shift_pix),
        .tap      (TAPS[i]),
        .sample   (win[i]),
        .prod     (prod[i])
      );
    end else begin : g_body
      fdec7_cell u_cell (
        .clk      (clk),
        .ctl      (cctl),
        .fill_pix (pixel_in),
        .sin      (win[i+1]),
        .tap      (TAPS[i]),
        .sample   (win[i]),
        .prod     (prod[i])
      );
    end
  end

  fdec7_round u_round (
    .clk       (clk),
    .rst       (rst),
    .prod      (prod),
    .tag       (tag2),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel_out (pixel_out),
    .last_out  (last_out)
  );

  a_end_starts_flush: assert property (@(posedge clk) disable iff (rst)
    (in_acc && line_end) |=> (flushing && pos == '0 && fstep == 2'd1))
    else $error("line end did not start a flush");

  a_fstep_range: assert property (@(posedge clk) disable iff (rst)
    flushing |-> (fstep != 2'd0))
    else $error("flush step out of range");

  a_last_tagged_valid: assert property (@(posedge clk) disable iff (rst)
    (!tag1.last || tag1.valid) && (!tag2.last || tag2.valid))
    else $error("last mark on an empty stage");

  a_flush_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    (flush_step && last_next) |=> (!flushing && tag1.valid && tag1.last))
    else $error("flush ended without a last result");

endmodule
